@@ hdl/fbsq_pkg.sv @@
// shared types and constants for the free/busy slot query block
package fbsq_pkg;

    // opcodes of the input channel
    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_QUERY  = 2'd2,
        OP_RSVD   = 2'd3
    } t_opcode;

    // configuration register indexes
    localparam logic CFG_CAL_START = 1'b0;
    localparam logic CFG_SLOT_MIN  = 1'b1;

    localparam int          CFG_W        = 40;
    localparam int          TIME_W       = 40;
    localparam int          SWT_W        = 41;
    localparam int          MIN_W        = 11;
    localparam int          LEN_W        = 17;
    localparam int          SECS_PER_MIN = 60;
    localparam logic [10:0] SLOT_MIN_RST = 11'd15;
    localparam logic [2:0]  NO_DATA      = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SPAN,
        S_CHECK,
        S_DIV,
        S_SINIT,
        S_SCAN,
        S_MUL,
        S_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic clear;
        logic append;
        logic cap_query;
        logic calc_span;
        logic check;
        logic div_step;
        logic scan_init;
        logic scan_step;
        logic mul;
        logic load_out;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic nodata;
        logic div_last;
        logic scan_done;
        logic found;
        logic out_free;
    } t_stat;

endpackage

@@ hdl/fbsq_ram.sv @@
// generic simple dual port ram with registered read
module fbsq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                 i_wdata,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_raddr,
    output logic [WIDTH-1:0]                 o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ hdl/fbsq_ctrl.sv @@
// sequencing state machine for the free/busy slot query block
module fbsq_ctrl
    import fbsq_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_opcode,
    input  t_stat      i_stat,
    output t_cmd       o_cmd
);
    t_state r_state;
    t_state n_state;
    logic   accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (t_opcode'(i_opcode))
                        OP_CLEAR:  o_cmd.clear = 1'b1;
                        OP_APPEND: o_cmd.append = 1'b1;
                        OP_QUERY: begin
                            o_cmd.cap_query = 1'b1;
                            n_state = S_SPAN;
                        end
                        default: ;
                    endcase
                end
            end
            S_SPAN: begin
                o_cmd.calc_span = 1'b1;
                n_state = S_CHECK;
            end
            S_CHECK: begin
                o_cmd.check = 1'b1;
                n_state = i_stat.nodata ? S_DONE : S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = S_SINIT;
                end
            end
            S_SINIT: begin
                o_cmd.scan_init = 1'b1;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_stat.scan_done) begin
                    n_state = i_stat.found ? S_MUL : S_DONE;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    property p_query_leaves_idle;
        @(posedge i_clk) disable iff (!i_rst_n)
            (accept && i_opcode == OP_QUERY) |=> (r_state == S_SPAN);
    endproperty
    a_query_leaves_idle: assert property (p_query_leaves_idle)
        else $error("query beat did not start the sequence");

    property p_cmd_beat_stays_idle;
        @(posedge i_clk) disable iff (!i_rst_n)
            (accept && i_opcode != OP_QUERY) |=> (r_state == S_IDLE);
    endproperty
    a_cmd_beat_stays_idle: assert property (p_cmd_beat_stays_idle)
        else $error("non-query beat left the idle state");

    property p_load_back_to_idle;
        @(posedge i_clk) disable iff (!i_rst_n)
            o_cmd.load_out |=> (r_state == S_IDLE);
    endproperty
    a_load_back_to_idle: assert property (p_load_back_to_idle)
        else $error("sequencer not idle after result load");
endmodule

@@ hdl/fbsq_dp.sv @@
// datapath: slot store, divider, forward scan and result register
module fbsq_dp
    import fbsq_pkg::*;
#(
    parameter int MAX_BYTES = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_stat             o_stat,
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [CFG_W-1:0]  i_cfg_data,
    input  logic [7:0]        i_load_byte,
    input  logic [TIME_W-1:0] i_query_time,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output logic [2:0]        o_status,
    output logic [9:0]        o_slot_index,
    output logic              o_switch_found,
    output logic [SWT_W-1:0]  o_chg_time,
    output logic [2:0]        o_next_status,
    output logic              o_overflow
);
    localparam int BW  = $clog2(MAX_BYTES + 1);
    localparam int AW  = $clog2(MAX_BYTES > 1 ? MAX_BYTES : 2);
    localparam int QW  = BW + 2;
    localparam int KW  = $clog2(QW);
    localparam int SPW = QW + LEN_W;

    // config and control state
    logic [TIME_W-1:0] r_start;
    logic [MIN_W-1:0]  r_slot_min;
    logic [BW-1:0]     r_bytes;
    logic              r_ovf;
    logic              r_out_valid;
    logic              r_pend;

    // payload
    logic [TIME_W:0]   r_diff;
    logic [LEN_W-1:0]  r_len;
    logic [SPW-1:0]    r_span;
    logic              r_nodata;
    logic [TIME_W-1:0] r_rem;
    logic [QW-1:0]     r_quot;
    logic [KW-1:0]     r_k;
    logic [BW-1:0]     r_ptr;
    logic [BW-1:0]     r_rd_ptr;
    logic [1:0]        r_cur;
    logic              r_found;
    logic [QW-1:0]     r_sw_slot;
    logic [1:0]        r_next_st;
    logic [SPW-1:0]    r_prod;
    logic [2:0]        r_o_status;
    logic [9:0]        r_o_index;
    logic              r_o_found;
    logic [SWT_W-1:0]  r_o_swt;
    logic [2:0]        r_o_next;
    logic              r_o_ovf;

    logic [QW-1:0]     slots;
    logic [TIME_W-1:0] trial;
    logic              nodata_c;
    logic [7:0]        rdata;
    logic              first;
    logic [1:0]        pos;
    logic [1:0]        cur_now;
    logic              hit;
    logic [1:0]        hit_j;
    logic              last_byte;
    logic              ram_we;
    logic [QW+9:0]     idx_ext;

    assign slots    = {r_bytes, 2'b00};
    assign trial    = TIME_W'(r_len) << r_k;
    assign nodata_c = (r_len == '0) || (r_bytes == '0) || r_diff[TIME_W]
                      || (r_diff[TIME_W-1:0] >= TIME_W'(r_span));
    assign ram_we   = i_cmd.append && (r_bytes < BW'(MAX_BYTES));

    fbsq_ram #(
        .WIDTH (8),
        .DEPTH (MAX_BYTES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_bytes[AW-1:0]),
        .i_wdata (i_load_byte),
        .i_raddr (r_ptr[AW-1:0]),
        .o_rdata (rdata)
    );

    // scan of one fetched byte, lowest differing slot wins
    assign first     = (r_rd_ptr == r_quot[QW-1:2]);
    assign pos       = r_quot[1:0];
    assign cur_now   = first ? 2'(rdata >> {pos, 1'b0}) : r_cur;
    assign last_byte = ({1'b0, r_rd_ptr} + 1'b1) == {1'b0, r_bytes};

    always_comb begin
        hit   = 1'b0;
        hit_j = 2'd0;
        for (int j = 3; j >= 0; j--) begin
            if ((rdata[2*j +: 2] != cur_now) && (!first || 2'(j) > pos)) begin
                hit   = 1'b1;
                hit_j = 2'(j);
            end
        end
    end

    assign o_stat.nodata    = nodata_c;
    assign o_stat.div_last  = (r_k == '0);
    assign o_stat.scan_done = r_pend && (hit || last_byte);
    assign o_stat.found     = hit;
    assign o_stat.out_free  = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start     <= '0;
            r_slot_min  <= SLOT_MIN_RST;
            r_bytes     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
            r_pend      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_CAL_START: r_start <= i_cfg_data;
                    CFG_SLOT_MIN:  r_slot_min <= i_cfg_data[MIN_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.clear) begin
                r_bytes <= '0;
                r_ovf   <= 1'b0;
            end else if (i_cmd.append) begin
                if (ram_we) begin
                    r_bytes <= r_bytes + 1'b1;
                end else begin
                    r_ovf <= 1'b1;
                end
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.scan_init) begin
                r_pend <= 1'b0;
            end else if (i_cmd.scan_step) begin
                r_pend <= (r_ptr < r_bytes);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_query) begin
            r_diff <= {1'b0, i_query_time} - {1'b0, r_start};
            r_len  <= LEN_W'(r_slot_min) * LEN_W'(SECS_PER_MIN);
        end
        if (i_cmd.calc_span) begin
            r_span <= SPW'(slots) * SPW'(r_len);
        end
        if (i_cmd.check) begin
            r_nodata <= nodata_c;
            r_rem    <= r_diff[TIME_W-1:0];
            r_quot   <= '0;
            r_k      <= KW'(QW - 1);
        end
        // restoring division, one quotient bit a cycle
        if (i_cmd.div_step) begin
            if (r_rem >= trial) begin
                r_rem       <= r_rem - trial;
                r_quot[r_k] <= 1'b1;
            end
            r_k <= r_k - 1'b1;
        end
        if (i_cmd.scan_init) begin
            r_ptr   <= r_quot[QW-1:2];
            r_found <= 1'b0;
        end
        if (i_cmd.scan_step) begin
            if (r_ptr < r_bytes) begin
                r_ptr <= r_ptr + 1'b1;
            end
            r_rd_ptr <= r_ptr;
            if (r_pend) begin
                if (first) begin
                    r_cur <= cur_now;
                end
                if (hit) begin
                    r_found   <= 1'b1;
                    r_sw_slot <= {r_rd_ptr, hit_j};
                    r_next_st <= rdata[2*hit_j +: 2];
                end
            end
        end
        if (i_cmd.mul) begin
            r_prod <= SPW'(r_sw_slot) * SPW'(r_len);
        end
        // change time is start plus the product register
        if (i_cmd.load_out) begin
            r_o_status <= r_nodata ? NO_DATA : {1'b0, r_cur};
            r_o_index  <= r_nodata ? 10'd0 : idx_ext[9:0];
            r_o_found  <= !r_nodata && r_found;
            r_o_swt    <= (!r_nodata && r_found) ?
                          (SWT_W'(r_start) + SWT_W'(r_prod)) : '0;
            r_o_next   <= (!r_nodata && r_found) ? {1'b0, r_next_st} : NO_DATA;
            r_o_ovf    <= r_ovf;
        end
    end

    assign idx_ext = {10'd0, r_quot};

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_o_status;
    assign o_slot_index   = r_o_index;
    assign o_switch_found = r_o_found;
    assign o_chg_time     = r_o_swt;
    assign o_next_status  = r_o_next;
    assign o_overflow     = r_o_ovf;

    property p_full_sets_ovf;
        @(posedge i_clk) disable iff (!i_rst_n)
            (i_cmd.append && !i_cmd.clear && r_bytes == BW'(MAX_BYTES)) |=> r_ovf;
    endproperty
    a_full_sets_ovf: assert property (p_full_sets_ovf)
        else $error("append into a full store did not flag overflow");

    property p_clear_empties;
        @(posedge i_clk) disable iff (!i_rst_n)
            i_cmd.clear |=> (!r_ovf && r_bytes == '0);
    endproperty
    a_clear_empties: assert property (p_clear_empties)
        else $error("clear left bytes or overflow behind");

    property p_quot_in_span;
        @(posedge i_clk) disable iff (!i_rst_n)
            i_cmd.scan_init |-> (r_quot < slots);
    endproperty
    a_quot_in_span: assert property (p_quot_in_span)
        else $error("slot index past loaded span after divide");

    property p_switch_after_query;
        @(posedge i_clk) disable iff (!i_rst_n)
            (i_cmd.scan_step && r_pend && hit) |=> (r_sw_slot > r_quot);
    endproperty
    a_switch_after_query: assert property (p_switch_after_query)
        else $error("switch slot not later than query slot");

    property p_load_when_free;
        @(posedge i_clk) disable iff (!i_rst_n)
            i_cmd.load_out |-> (!r_out_valid || i_out_ready);
    endproperty
    a_load_when_free: assert property (p_load_when_free)
        else $error("result register overwritten while held");
endmodule

@@ hdl/free_busy_slot_query.sv @@
// top level of the free/busy slot query block
//
// input channel (i_in_valid / o_in_ready) carries one beat per command:
//   clear store, append one byte of four 2-bit slot states, or query a time
// clear and append keep the sequencer idle and give no result beat
// a query gives exactly one beat on the output channel (o_out_valid / i_out_ready)
// a query steps through span, check, divide, scan init and scan, then multiply only
//   when a later change is found, then waits in done for a free result register;
//   QW = clog2(MAX_BYTES+1) + 2 is the restoring divider (one quotient bit a cycle),
//   the forward scan reads the stored bytes from the query slot on, one ram read
//   port, four slots a cycle; a query before the start, past the loaded span, with
//   an empty store or zero slot length skips divide and scan; the input is taken
//   only while the sequencer is idle, one query at a time
// the result register parts the two sides: clear and append beats are taken
//   while a finished result waits, a new query completes once it is drained
// a stalled receiver just holds the result beat, nothing is lost
// the config port directly writes the calendar start (index 0) and the slot length
//   in minutes (index 1); the user does so only while the block is idle, unenforced
// reset empties the store count and overflow flag, start 0, 15 minute slots;
//   the slot store itself needs no clearing pass
module free_busy_slot_query
    import fbsq_pkg::*;
#(
    parameter int MAX_BYTES = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // config write port
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [CFG_W-1:0]  i_cfg_data,
    // command beats
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [1:0]        i_opcode,
    input  logic [7:0]        i_load_byte,
    input  logic [TIME_W-1:0] i_query_time,
    // result beats
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [2:0]        o_status,
    output logic [9:0]        o_slot_index,
    output logic              o_switch_found,
    output logic [SWT_W-1:0]  o_chg_time,
    output logic [2:0]        o_next_status,
    output logic              o_overflow
);
    t_cmd  cmd;
    t_stat stat;

    // sequencer: accepts beats and steps the datapath through a query
    fbsq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_opcode   (i_opcode),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // store, span check, divider, scan, change time and result register
    fbsq_dp #(
        .MAX_BYTES (MAX_BYTES)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_load_byte    (i_load_byte),
        .i_query_time   (i_query_time),
        .i_out_ready    (i_out_ready),
        .o_out_valid    (o_out_valid),
        .o_status       (o_status),
        .o_slot_index   (o_slot_index),
        .o_switch_found (o_switch_found),
        .o_chg_time     (o_chg_time),
        .o_next_status  (o_next_status),
        .o_overflow     (o_overflow)
    );
endmodule

@@ sim/testbench.sv @@
// self-checking testbench for the free/busy slot query block
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import fbsq_pkg::*;

    // store depth of the block under test
    localparam int CAL_BYTES = 256;

    // run shape
    localparam int RAND_ITEMS    = 1400;
    localparam int N_PHASES      = 8;
    localparam int HOLD_CYCLES   = 600;
    localparam int SETTLE_CYCLES = 20;
    localparam int TAIL_CYCLES   = 300;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int TIMEOUT_NS    = 5_000_000;
    localparam int REPORT_MAX    = 10;

    localparam logic [TIME_W-1:0] MAX_TIME = '1;

    // slot state codes as they appear in the status fields
    localparam logic [2:0] ST_FREE = 3'd0;
    localparam logic [2:0] ST_TENT = 3'd1;
    localparam logic [2:0] ST_BUSY = 3'd2;
    localparam logic [2:0] ST_OOO  = 3'd3;

    // one result beat, field by field
    typedef struct packed {
        logic [2:0]       status;
        logic [9:0]       slot_index;
        logic             switch_found;
        logic [SWT_W-1:0] chg_time;
        logic [2:0]       next_status;
        logic             overflow;
    } t_answer;

    localparam t_answer ANS_NONE = '{NO_DATA, 10'd0, 1'b0, 41'd0, NO_DATA, 1'b0};

    // one row of the directed part; typed rows carry their answer, others use the predictor
    typedef struct packed {
        t_opcode           op;
        logic [7:0]        load_val;
        logic [TIME_W-1:0] qtime;
        logic              typed;
        t_answer           ans;
    } t_drill_row;

    // reset setting: start 0, 15 minute slots, so one slot is 900 s
    localparam int DRILL_N = 22;
    localparam t_drill_row DRILL [DRILL_N] = '{
        // empty store after reset
        '{OP_QUERY,  8'h00, 40'd0,          1'b1, ANS_NONE},
        // reserved opcode with every payload bit set, ignored
        '{OP_RSVD,   8'hFF, MAX_TIME,       1'b0, ANS_NONE},
        // slots 0-3 free, 4-7 out of office, then free/tentative/busy/out of office
        '{OP_APPEND, 8'h00, 40'd0,          1'b0, ANS_NONE},
        '{OP_APPEND, 8'hFF, 40'd0,          1'b0, ANS_NONE},
        '{OP_APPEND, 8'hE4, 40'd0,          1'b0, ANS_NONE},
        // first slot, change found at slot 4
        '{OP_QUERY,  8'h00, 40'd0,          1'b1,
          '{ST_FREE, 10'd0, 1'b1, 41'd3600, ST_OOO, 1'b0}},
        '{OP_QUERY,  8'h5A, 40'd899,        1'b0, ANS_NONE},
        '{OP_QUERY,  8'hA5, 40'd3600,       1'b0, ANS_NONE},
        // last loaded slot, nothing later
        '{OP_QUERY,  8'h00, 40'd9900,       1'b1,
          '{ST_OOO, 10'd11, 1'b0, 41'd0, NO_DATA, 1'b0}},
        '{OP_QUERY,  8'h00, 40'd10799,      1'b0, ANS_NONE},
        // exactly at the end of the span, then the largest time
        '{OP_QUERY,  8'h00, 40'd10800,      1'b1, ANS_NONE},
        '{OP_QUERY,  8'hFF, MAX_TIME,       1'b1, ANS_NONE},
        // all busy byte extends the span past slot 11
        '{OP_APPEND, 8'hAA, 40'd0,          1'b0, ANS_NONE},
        '{OP_QUERY,  8'h00, 40'd9900,       1'b0, ANS_NONE},
        '{OP_QUERY,  8'h00, 40'd9000,       1'b0, ANS_NONE},
        // clear, then the store is empty again
        '{OP_CLEAR,  8'h3C, 40'hAB_CDEF_0123, 1'b0, ANS_NONE},
        '{OP_QUERY,  8'h00, 40'd0,          1'b1, ANS_NONE},
        // all tentative, no change anywhere
        '{OP_APPEND, 8'h55, 40'd0,          1'b0, ANS_NONE},
        '{OP_APPEND, 8'h55, 40'd0,          1'b0, ANS_NONE},
        '{OP_QUERY,  8'h00, 40'd1800,       1'b1,
          '{ST_TENT, 10'd2, 1'b0, 41'd0, NO_DATA, 1'b0}},
        '{OP_QUERY,  8'h00, 40'd7199,       1'b0, ANS_NONE},
        '{OP_CLEAR,  8'hC3, 40'h54_3210_FEDC, 1'b0, ANS_NONE}
    };

    // dut ports
    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic              i_cfg_idx;
    logic [CFG_W-1:0]  i_cfg_data;
    logic              i_in_valid;
    logic              o_in_ready;
    logic [1:0]        i_opcode;
    logic [7:0]        i_load_byte;
    logic [TIME_W-1:0] i_query_time;
    logic              o_out_valid;
    logic              i_out_ready;
    logic [2:0]        o_status;
    logic [9:0]        o_slot_index;
    logic              o_switch_found;
    logic [SWT_W-1:0]  o_chg_time;
    logic [2:0]        o_next_status;
    logic              o_overflow;

    // calendar model: store, fill count, sticky overflow and the two registers
    logic [7:0]        cal_bytes [CAL_BYTES];
    int unsigned       cal_count;
    logic              cal_ovf;
    logic [TIME_W-1:0] cfg_start;
    logic [MIN_W-1:0]  cfg_minutes;

    // answers still owed by the block, oldest first
    t_answer answers_due [$];

    // idling and receiver hold-off control
    int tx_idle_pct;
    int rx_idle_pct;
    int hold_reqs;
    int hold_seen;
    int hold_left;

    // bookkeeping
    int error_cnt;
    int n_cmds;
    int n_queries;
    int n_nodata;
    int n_switch;
    int n_ovf_answers;
    int n_beats;
    int n_settings;

    free_busy_slot_query #(
        .MAX_BYTES(CAL_BYTES)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_opcode       (i_opcode),
        .i_load_byte    (i_load_byte),
        .i_query_time   (i_query_time),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_status       (o_status),
        .o_slot_index   (o_slot_index),
        .o_switch_found (o_switch_found),
        .o_chg_time     (o_chg_time),
        .o_next_status  (o_next_status),
        .o_overflow     (o_overflow)
    );

    // 2 ns clock
    always #1 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // calendar model
    // ------------------------------------------------------------------

    // 2-bit state of slot s, low bits of each byte first
    function automatic logic [1:0] slot_state_at(input longint unsigned s);
        return 2'(cal_bytes[int'(s >> 2)] >> (2 * (s & 64'd3)));
    endfunction

    // apply one accepted command beat to the model; 1 when it owes a result
    function automatic logic answer_for_beat(input t_opcode op, input logic [7:0] load_val,
                                             input logic [TIME_W-1:0] qtime,
                                             output t_answer ans);
        longint unsigned len;
        longint unsigned slots;
        longint unsigned q;
        longint unsigned st;
        longint unsigned idx;
        longint unsigned s;
        logic [1:0]      cur;
        logic [1:0]      nxt;
        ans = ANS_NONE;
        if (op == OP_CLEAR) begin
            cal_count = 0;
            cal_ovf   = 1'b0;
            return 1'b0;
        end
        if (op == OP_APPEND) begin
            // full store drops the byte and latches overflow
            if (cal_count < CAL_BYTES) begin
                cal_bytes[cal_count] = load_val;
                cal_count++;
            end else begin
                cal_ovf = 1'b1;
            end
            return 1'b0;
        end
        if (op != OP_QUERY)
            return 1'b0;

        ans.overflow = cal_ovf;
        len   = 64'(cfg_minutes) * SECS_PER_MIN;
        slots = 64'(cal_count) * 4;
        q     = 64'(qtime);
        st    = 64'(cfg_start);
        // no slot length, empty store, before the start or past the loaded span
        if (len == 0 || slots == 0 || q < st)
            return 1'b1;
        if (q - st >= slots * len)
            return 1'b1;

        idx = (q - st) / len;
        cur = slot_state_at(idx);
        ans.status     = {1'b0, cur};
        ans.slot_index = idx[9:0];
        // forward scan for the first slot with another state
        for (s = idx + 1; s < slots; s++) begin
            nxt = slot_state_at(s);
            if (nxt != cur) begin
                ans.switch_found = 1'b1;
                ans.chg_time     = SWT_W'(st + s * len);
                ans.next_status  = {1'b0, nxt};
                break;
            end
        end
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    function automatic logic [TIME_W-1:0] rand40();
        return {8'($urandom_range(255)), 32'($urandom())};
    endfunction

    // query time: mostly inside the loaded span, also just before it, at its end, anywhere
    function automatic logic [TIME_W-1:0] pick_query_time();
        longint unsigned len;
        longint unsigned span;
        longint unsigned st;
        longint unsigned t;
        longint unsigned off;
        int              r;
        len  = 64'(cfg_minutes) * SECS_PER_MIN;
        span = 64'(cal_count) * 4 * len;
        st   = 64'(cfg_start);
        r    = $urandom_range(99);
        if (span != 0 && r < 65) begin
            case ($urandom_range(3))
                0:       off = 0;
                1:       off = len - 1;
                default: off = $urandom_range(32'(len - 1));
            endcase
            t = st + 64'($urandom_range(cal_count * 4 - 1)) * len + off;
        end else if (r < 75 && st != 0) begin
            t = (st > 3000) ? st - 1 - $urandom_range(3000) : st - 1;
        end else if (r < 88 && span != 0) begin
            // last second of the span or the first one past it
            t = st + span - $urandom_range(1);
        end else begin
            t = 64'(rand40());
        end
        if (t > 64'(MAX_TIME))
            t = 64'(MAX_TIME);
        return t[TIME_W-1:0];
    endfunction

    function automatic void pick_idle(input int ph);
        if (ph < 3) begin
            tx_idle_pct = 12;
            rx_idle_pct = 76;
        end else if (ph < 6) begin
            tx_idle_pct = 76;
            rx_idle_pct = 12;
        end else begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
        end
    endfunction

    function automatic void note_fault(input string msg);
        error_cnt++;
        if (error_cnt <= REPORT_MAX)
            $display("[%0t] ERROR %s", $realtime, msg);
    endfunction

    // offer one command beat, record it in the model at the edge it is taken
    // entered and left just after a falling edge
    task automatic push_cmd(input t_opcode op, input logic [7:0] load_val,
                            input logic [TIME_W-1:0] qtime,
                            input logic use_typed = 1'b0, input t_answer typed_ans = ANS_NONE);
        t_answer ans;
        t_answer owed;
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_opcode     <= op;
        i_load_byte  <= load_val;
        i_query_time <= qtime;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        if (answer_for_beat(op, load_val, qtime, ans)) begin
            owed = use_typed ? typed_ans : ans;
            answers_due.push_back(owed);
            n_queries++;
            if (owed.status == NO_DATA)
                n_nodata++;
            if (owed.switch_found)
                n_switch++;
            if (owed.overflow)
                n_ovf_answers++;
        end
        if (op != OP_RSVD)
            n_cmds++;
        @(negedge i_clk);
    endtask

    // sender pause: nothing offered until every owed answer has come back
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (answers_due.size() != 0)
            @(negedge i_clk);
        // clear and append beats may still be in flight
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // both registers, back to back, only while idle
    task automatic set_calendar(input logic [TIME_W-1:0] start_s,
                                input logic [MIN_W-1:0] minutes);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_CAL_START;
        i_cfg_data <= start_s;
        @(posedge i_clk);
        cfg_start = start_s;
        @(negedge i_clk);
        // junk above the slot length field, the register keeps only its 11 bits
        i_cfg_idx  <= CFG_SLOT_MIN;
        i_cfg_data <= {29'($urandom()), minutes};
        @(posedge i_clk);
        cfg_minutes = minutes;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        n_settings++;
    endtask

    // one calendar load: optional clear, n bytes, then a few queries
    task automatic run_sequence(input int n_bytes, input logic fresh, input int n_q);
        int         style;
        logic [7:0] run_val;
        logic [7:0] b;
        style   = $urandom_range(3);
        run_val = {4{2'($urandom_range(3))}};
        if (fresh)
            push_cmd(OP_CLEAR, 8'($urandom()), rand40());
        for (int i = 0; i < n_bytes; i++) begin
            // stray reserved beat now and then
            if ($urandom_range(99) < 3)
                push_cmd(OP_RSVD, 8'($urandom()), rand40());
            case (style)
                0: b = 8'($urandom());
                1: begin
                    // long runs of one state, occasional change
                    if ($urandom_range(9) == 0)
                        run_val = {4{2'($urandom_range(3))}};
                    b = run_val;
                end
                2: b = ($urandom_range(7) == 0) ? 8'($urandom()) : 8'h00;
                default: b = run_val;
            endcase
            push_cmd(OP_APPEND, b, rand40());
        end
        for (int k = 0; k < n_q; k++)
            push_cmd(OP_QUERY, 8'($urandom()), pick_query_time());
    endtask

    // ------------------------------------------------------------------
    // receiver: random ready, long hold-off on request
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (hold_seen != hold_reqs) begin
            hold_seen = hold_reqs;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // result checker: every accepted beat against the oldest owed answer
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : result_check
        t_answer got;
        t_answer want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = '{o_status, o_slot_index, o_switch_found, o_chg_time,
                    o_next_status, o_overflow};
            n_beats++;
            if (answers_due.size() == 0) begin
                note_fault($sformatf("result beat %0d with no query owed", n_beats));
            end else begin
                want = answers_due.pop_front();
                if (got.status !== want.status || got.slot_index !== want.slot_index ||
                    got.switch_found !== want.switch_found ||
                    got.chg_time !== want.chg_time ||
                    got.next_status !== want.next_status || got.overflow !== want.overflow)
                    note_fault($sformatf(
                        {"result beat %0d: expected st=%0d idx=%0d sw=%0b t=%0d nx=%0d ovf=%0b,",
                         " got st=%0d idx=%0d sw=%0b t=%0d nx=%0d ovf=%0b"},
                        n_beats, want.status, want.slot_index, want.switch_found,
                        want.chg_time, want.next_status, want.overflow,
                        got.status, got.slot_index, got.switch_found,
                        got.chg_time, got.next_status, got.overflow));
            end
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        int                ph;
        int                r;
        int                nb;
        int                base;
        int                guard;
        logic [TIME_W-1:0] st;
        logic [MIN_W-1:0]  mn;

        // known values on every input from time zero
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = CFG_CAL_START;
        i_cfg_data   = '0;
        i_in_valid   = 1'b0;
        i_opcode     = OP_CLEAR;
        i_load_byte  = '0;
        i_query_time = '0;
        i_out_ready  = 1'b0;
        tx_idle_pct  = 0;
        rx_idle_pct  = 0;
        hold_reqs    = 0;
        hold_seen    = 0;
        hold_left    = 0;

        // model state after reset
        cal_count   = 0;
        cal_ovf     = 1'b0;
        cfg_start   = '0;
        cfg_minutes = SLOT_MIN_RST;

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed walk at the reset setting
        pick_idle(0);
        foreach (DRILL[k])
            push_cmd(DRILL[k].op, DRILL[k].load_val, DRILL[k].qtime, DRILL[k].typed,
                     DRILL[k].ans);

        // random phases, one register setting each, extremes among them
        base = n_cmds;
        for (ph = 0; ph < N_PHASES; ph++) begin
            wait_drained();
            case (ph)
                0: begin st = rand40();         mn = 11'd1;    end
                1: begin st = MAX_TIME;         mn = 11'd1440; end
                2: begin st = rand40();         mn = 11'd0;    end
                3: begin st = rand40();         mn = 11'd2047; end
                4: begin st = '0;               mn = 11'd15;   end
                5: begin st = 40'($urandom());  mn = 11'($urandom_range(1, 1440)); end
                6: begin st = rand40();         mn = 11'd60;   end
                default: begin st = rand40();   mn = 11'($urandom_range(1, 2047)); end
            endcase
            set_calendar(st, mn);
            pick_idle(ph);

            if (ph == 4) begin
                // receiver holds off while queries keep coming, input must back up
                hold_reqs++;
                run_sequence(4, 1'b1, 6);
                // full store plus dropped bytes
                run_sequence(CAL_BYTES + 2, 1'b1, 3);
            end

            while (n_cmds - base < (ph + 1) * RAND_ITEMS / N_PHASES) begin
                r = $urandom_range(99);
                if (r < 1)
                    nb = $urandom_range(240, 262);
                else if (r < 15)
                    nb = $urandom_range(13, 80);
                else if (r < 20)
                    nb = 0;
                else
                    nb = $urandom_range(1, 12);
                run_sequence(nb, $urandom_range(99) < 75, $urandom_range(1, 5));
            end
        end

        // stimulus done, let everything owed come out
        i_in_valid <= 1'b0;
        guard = 0;
        while (answers_due.size() != 0 && guard < DRAIN_LIMIT) begin
            @(negedge i_clk);
            guard++;
        end
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (answers_due.size() != 0)
            note_fault($sformatf("%0d query results never came", answers_due.size()));

        $display("covered %0d commands over %0d register settings: %0d queries, %0d no-data,",
                 n_cmds, n_settings, n_queries, n_nodata);
        $display("  %0d with a later change, %0d showing overflow, %0d result beats checked",
                 n_switch, n_ovf_answers, n_beats);
        if (error_cnt == 0)
            $display("** free_busy_slot_query: PASSED **");
        else
            $display("** free_busy_slot_query: FAILED **");
        $finish;
    end

    // hard stop if the handshakes hang
    initial begin
        #(TIMEOUT_NS);
        $display("timeout after %0d ns", TIMEOUT_NS);
        $display("** free_busy_slot_query: FAILED **");
        $finish;
    end

endmodule
